// File: hdl/ms_pkg.sv
// ----------------------------------------------------------------------------
// ms_pkg
// Shared constants and types of the merge sorter: data width, default
// capacity and the sequencer states.
// ----------------------------------------------------------------------------
package ms_pkg;

  // Width of one element, two's complement.
  localparam int DATA_W = 32;

  // Default number of elements one set may hold.
  localparam int CAPACITY_DEF = 64;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_LOAD,   // collecting elements into bank A
    ST_SETUP,  // set closed, choose between sorting and direct output
    ST_RUN,    // set up the next pair of runs to merge
    ST_MERGE,  // merge one element per cycle into the other bank
    ST_EMIT    // stream the sorted set out
  } state_t;

endpackage

// File: hdl/ms_if.sv
// ----------------------------------------------------------------------------
// ms_if
// Valid/ready channels of the merge sorter: the element input channel and
// the sorted result channel.
// ----------------------------------------------------------------------------

// Input channel: one element per item, last closes the set.
interface ms_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [ms_pkg::DATA_W-1:0]  value;
  logic                              last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// Result channel: one sorted element per item, final_res on the greatest.
interface ms_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ms_pkg::DATA_W-1:0]  sorted_value;
  logic                              final_res;

  modport source (output valid, output sorted_value, output final_res, input ready);
  modport sink   (input valid, input sorted_value, input final_res, output ready);
endinterface

// File: hdl/merge_sorter_core.sv
// Loading takes one item per cycle; the set closes with the item marked last.
// Sorting: a setup state, then per pass (width 1, 2, 4, ...) a run state per run pair
// and a merge step per element, limited by the single write port of the target bank.
// Output: up to one item per cycle.
// Synchronous active-low reset clears the sequencer, fill count and output valid;
// the two banks are not cleared and are only read where written in the current set.
// ----------------------------------------------------------------------------
// merge_sorter_core
// Collects a set of signed elements in bank A, sorts it ascending with
// bottom-up merge passes that alternate between banks A and B (stable on
// ties) and streams the sorted set out through an output register.
// ----------------------------------------------------------------------------
module merge_sorter_core #(
  parameter int CAPACITY = ms_pkg::CAPACITY_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  ms_in_if.sink    in_ch,
  ms_out_if.source out_ch
);

  localparam int DW = ms_pkg::DATA_W;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // Element banks with registered reads at two addresses.
  logic [DW-1:0] bank_a [CAPACITY];
  logic [DW-1:0] bank_b [CAPACITY];

  ms_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW:0]   width_r, width_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          src_sel_r, src_sel_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [DW-1:0] out_value_r, out_value_nxt;
  logic          out_final_r, out_final_nxt;

  logic [DW-1:0] rd_a_i_r, rd_a_j_r, rd_b_i_r, rd_b_j_r;
  logic [DW-1:0] src_i, src_j;

  logic          we_a, we_b;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;

  logic          in_fire;
  logic          fill_room;
  logic [CW-1:0] fill_inc;
  logic          take_i;
  logic          run_end;
  logic          pass_end;
  logic          sort_end;
  logic [CW:0]   width_dbl;
  logic [CW:0]   mid_sum;
  logic [CW+1:0] hi_sum;
  logic [CW-1:0] mid_val;
  logic [CW-1:0] hi_val;
  logic          emit_go;
  logic          emit_last;

  // Handshake and shared conditions.
  assign in_ch.ready = (state_r == ms_pkg::ST_LOAD);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign fill_room   = (fill_r < CW'(CAPACITY));
  assign fill_inc    = fill_room ? CW'(fill_r + 1'b1) : fill_r;

  // Read data of the current source bank.
  assign src_i = src_sel_r ? rd_b_i_r : rd_a_i_r;
  assign src_j = src_sel_r ? rd_b_j_r : rd_a_j_r;

  // Merge decision: the left run wins ties, which keeps the sort stable.
  assign take_i = (i_r < mid_r) &&
                  ((j_r >= hi_r) || ($signed(src_i) <= $signed(src_j)));
  assign run_end   = (CW'(k_r + 1'b1) == hi_r);
  assign pass_end  = run_end && (hi_r == fill_r);
  assign width_dbl = width_r << 1;
  assign sort_end  = pass_end && (width_dbl >= {1'b0, fill_r});

  // Bounds of the next run pair, clipped to the set size.
  assign mid_sum = {1'b0, lo_r} + width_r;
  assign hi_sum  = {2'b00, lo_r} + {width_r, 1'b0};
  assign mid_val = (mid_sum > {1'b0, fill_r}) ? fill_r : mid_sum[CW-1:0];
  assign hi_val  = (hi_sum > {2'b00, fill_r}) ? fill_r : hi_sum[CW-1:0];

  // Output stage is free when empty or being drained.
  assign emit_go   = !out_valid_r || out_ch.ready;
  assign emit_last = (CW'(i_r + 1'b1) == fill_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ms_pkg::ST_LOAD: begin
        if (in_fire && in_ch.last) state_nxt = ms_pkg::ST_SETUP;
      end
      ms_pkg::ST_SETUP: begin
        if (fill_r <= CW'(1)) state_nxt = ms_pkg::ST_EMIT;
        else                  state_nxt = ms_pkg::ST_RUN;
      end
      ms_pkg::ST_RUN: begin
        state_nxt = ms_pkg::ST_MERGE;
      end
      ms_pkg::ST_MERGE: begin
        if (run_end) begin
          if (sort_end) state_nxt = ms_pkg::ST_EMIT;
          else          state_nxt = ms_pkg::ST_RUN;
        end
      end
      ms_pkg::ST_EMIT: begin
        if (emit_go && emit_last) state_nxt = ms_pkg::ST_LOAD;
      end
      default: state_nxt = ms_pkg::ST_LOAD;
    endcase
  end

  // Datapath and memory control for each state.
  always_comb begin
    fill_nxt      = fill_r;
    width_nxt     = width_r;
    lo_nxt        = lo_r;
    mid_nxt       = mid_r;
    hi_nxt        = hi_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    src_sel_nxt   = src_sel_r;
    out_value_nxt = out_value_r;
    out_final_nxt = out_final_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    we_a          = 1'b0;
    we_b          = 1'b0;
    wr_addr       = fill_r[AW-1:0];
    wr_data       = in_ch.value;
    case (state_r)
      ms_pkg::ST_LOAD: begin
        // Store the item while room remains; overflow items are dropped.
        if (in_fire) begin
          we_a     = fill_room;
          fill_nxt = fill_inc;
        end
      end
      ms_pkg::ST_SETUP: begin
        width_nxt   = (CW + 1)'(1);
        lo_nxt      = '0;
        i_nxt       = '0;
        src_sel_nxt = 1'b0;
      end
      ms_pkg::ST_RUN: begin
        mid_nxt = mid_val;
        hi_nxt  = hi_val;
        i_nxt   = lo_r;
        j_nxt   = mid_val;
        k_nxt   = lo_r;
      end
      ms_pkg::ST_MERGE: begin
        // One element into the other bank; reads follow the next indices.
        wr_addr = k_r[AW-1:0];
        wr_data = take_i ? src_i : src_j;
        we_a    = src_sel_r;
        we_b    = !src_sel_r;
        k_nxt   = CW'(k_r + 1'b1);
        if (take_i) i_nxt = CW'(i_r + 1'b1);
        else        j_nxt = CW'(j_r + 1'b1);
        if (run_end) begin
          lo_nxt = hi_r;
          if (pass_end) begin
            lo_nxt      = '0;
            width_nxt   = width_dbl;
            src_sel_nxt = !src_sel_r;
          end
          if (sort_end) i_nxt = '0;
        end
      end
      ms_pkg::ST_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = src_i;
          out_final_nxt = emit_last;
          i_nxt         = CW'(i_r + 1'b1);
          if (emit_last) fill_nxt = '0;
        end
      end
      default: begin
        fill_nxt = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ms_pkg::ST_LOAD;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and index registers.
  always_ff @(posedge clk) begin
    width_r     <= width_nxt;
    lo_r        <= lo_nxt;
    mid_r       <= mid_nxt;
    hi_r        <= hi_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    src_sel_r   <= src_sel_nxt;
    out_value_r <= out_value_nxt;
    out_final_r <= out_final_nxt;
  end

  // Bank A: one write port, registered reads at the next merge indices.
  always_ff @(posedge clk) begin
    if (we_a) bank_a[wr_addr] <= wr_data;
    rd_a_i_r <= bank_a[i_nxt[AW-1:0]];
    rd_a_j_r <= bank_a[j_nxt[AW-1:0]];
  end

  // Bank B: same organisation as bank A.
  always_ff @(posedge clk) begin
    if (we_b) bank_b[wr_addr] <= wr_data;
    rd_b_i_r <= bank_b[i_nxt[AW-1:0]];
    rd_b_j_r <= bank_b[j_nxt[AW-1:0]];
  end

  // Result channel.
  assign out_ch.valid        = out_valid_r;
  assign out_ch.sorted_value = out_value_r;
  assign out_ch.final_res    = out_final_r;

endmodule
